/* rtl/nmea_chk_pkg.sv */
// Shared types and codes for the NMEA sentence checker.
// No dependencies; used by nmea_chk_parser and nmea_sentence_checker.
package nmea_chk_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;
  localparam int NUM_W  = 7;

  localparam logic [KIND_W-1:0] KIND_GLL   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RMC   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GSA   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GSV   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_VTG   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_GGA   = 3'd5;
  localparam logic [KIND_W-1:0] KIND_OTHER = 3'd6;

  typedef struct packed {
    logic              checksum_ok;
    logic [BYTE_W-1:0] computed_checksum;
    logic [BYTE_W-1:0] received_checksum;
    logic [KIND_W-1:0] sentence_kind;
    logic              time_present;
    logic [NUM_W-1:0]  utc_hour;
    logic [NUM_W-1:0]  utc_minute;
    logic [NUM_W-1:0]  utc_second;
    logic              sats_present;
    logic [NUM_W-1:0]  sats_in_view;
  } nmea_res_t;

endpackage

/* rtl/nmea_chk_parser.sv */
// Sentence state and per-byte update: phase, running XOR, checksum digits, fields.
// Depends on nmea_chk_pkg; instantiated by nmea_sentence_checker.
module nmea_chk_parser (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic [7:0]                rx_byte,
  output logic                      emit,
  output nmea_chk_pkg::nmea_res_t   res
);
  import nmea_chk_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_BODY = 3'd1;
  localparam logic [2:0] PH_CK1  = 3'd2;
  localparam logic [2:0] PH_CK2  = 3'd3;
  localparam logic [2:0] PH_TAIL = 3'd4;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;

  localparam logic [39:0] ID_GLL = 40'h4750474C4C;
  localparam logic [39:0] ID_RMC = 40'h4750524D43;
  localparam logic [39:0] ID_GSA = 40'h4750475341;
  localparam logic [39:0] ID_GSV = 40'h4750475356;
  localparam logic [39:0] ID_VTG = 40'h4750565447;
  localparam logic [39:0] ID_GGA = 40'h4750474741;

  localparam logic [3:0] NIB_BAD   = 4'hE;
  localparam logic [3:0] NIB_EMPTY = 4'hF;

  function automatic logic is_digit(input logic [7:0] b);
    is_digit = (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    if (is_digit(b)) hex_val = b[3:0];
    else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
      hex_val = 4'(b[3:0] + 4'd9);
    else hex_val = 4'd0;
  endfunction

  function automatic logic [KIND_W-1:0] kind_of(input logic [39:0] id);
    if (id == ID_GLL) kind_of = KIND_GLL;
    else if (id == ID_RMC) kind_of = KIND_RMC;
    else if (id == ID_GSA) kind_of = KIND_GSA;
    else if (id == ID_GSV) kind_of = KIND_GSV;
    else if (id == ID_VTG) kind_of = KIND_VTG;
    else if (id == ID_GGA) kind_of = KIND_GGA;
    else kind_of = KIND_OTHER;
  endfunction

  // Bit 7 marks the end of the leading digits; bits 6:0 saturate at 127.
  function automatic logic [7:0] num_step(input logic [7:0] acc, input logic [7:0] b);
    logic [10:0] v;
    v = 11'(acc[6:0]) * 11'd10 + 11'(b[3:0]);
    if (acc[7]) num_step = acc;
    else if (!is_digit(b)) num_step = acc | 8'h80;
    else if (v > 11'd127) num_step = 8'd127;
    else num_step = v[7:0];
  endfunction

  function automatic logic [NUM_W-1:0] two_digits(input logic [3:0] a, input logic [3:0] b);
    if (a > 4'd9) two_digits = '0;
    else if (b > 4'd9) two_digits = NUM_W'(a);
    else two_digits = NUM_W'(a) * NUM_W'(10) + NUM_W'(b);
  endfunction

  logic [2:0]       phase_r, phase_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic [7:0]       rxs_r, rxs_nxt;
  logic [3:0]       fidx_r, fidx_nxt;
  logic [2:0]       cidx_r, cidx_nxt;
  logic [39:0]      id_r, id_nxt;
  logic [5:0][3:0]  td_r, td_nxt;
  logic [7:0]       gmsg_r, gmsg_nxt;
  logic [7:0]       gcnt_r, gcnt_nxt;
  logic             cr_r, cr_nxt;

  logic             active;
  logic [KIND_W-1:0] kind_cur;
  logic             time_fld;
  logic [39:0]      id_fin;
  logic [KIND_W-1:0] kind_fin;
  logic             ok;

  assign active   = (phase_r >= PH_BODY) && (phase_r <= PH_TAIL);
  assign kind_cur = kind_of(id_r);
  assign time_fld = (kind_cur == KIND_GLL && fidx_r == 4'd5) ||
                    (kind_cur == KIND_RMC && fidx_r == 4'd1);

  always_comb begin
    phase_nxt = phase_r;
    xor_nxt   = xor_r;
    rxs_nxt   = rxs_r;
    fidx_nxt  = fidx_r;
    cidx_nxt  = cidx_r;
    id_nxt    = id_r;
    td_nxt    = td_r;
    gmsg_nxt  = gmsg_r;
    gcnt_nxt  = gcnt_r;
    cr_nxt    = cr_r;
    emit      = 1'b0;

    if (!active) begin
      if (rx_byte == CH_DOLLAR) begin
        phase_nxt = PH_BODY;
        xor_nxt   = '0;
        rxs_nxt   = '0;
        fidx_nxt  = '0;
        cidx_nxt  = '0;
        id_nxt    = '0;
        td_nxt    = {6{NIB_EMPTY}};
        gmsg_nxt  = '0;
        gcnt_nxt  = '0;
        cr_nxt    = 1'b0;
      end
    end else begin
      if (rx_byte == CH_STAR) begin
        // restart digit capture on every star
        phase_nxt = PH_CK1;
        rxs_nxt   = '0;
      end else begin
        unique case (phase_r)
          PH_BODY: begin
            if (rx_byte != CH_DOLLAR) begin
              xor_nxt = xor_r ^ rx_byte;
              if (rx_byte == CH_COMMA) begin
                // drop an identifier of the wrong length
                if (fidx_r == '0 && cidx_r != 3'd5) id_nxt = '0;
                if (fidx_r != 4'd15) fidx_nxt = fidx_r + 4'd1;
                cidx_nxt = '0;
              end else begin
                if (fidx_r == '0) begin
                  for (int i = 0; i < 5; i++) begin
                    if (cidx_r == 3'(i)) id_nxt[8*(4-i) +: 8] = id_r[8*(4-i) +: 8] | rx_byte;
                  end
                end else begin
                  if (time_fld) begin
                    for (int i = 0; i < 6; i++) begin
                      if (cidx_r == 3'(i))
                        td_nxt[5-i] = is_digit(rx_byte) ? rx_byte[3:0] : NIB_BAD;
                    end
                  end
                  if (kind_cur == KIND_GSV && fidx_r == 4'd2) gmsg_nxt = num_step(gmsg_r, rx_byte);
                  if (kind_cur == KIND_GSV && fidx_r == 4'd3) gcnt_nxt = num_step(gcnt_r, rx_byte);
                end
                if (cidx_r != 3'd7) cidx_nxt = cidx_r + 3'd1;
              end
            end
          end
          PH_CK1: begin
            rxs_nxt   = {hex_val(rx_byte), 4'h0};
            phase_nxt = PH_CK2;
          end
          PH_CK2: begin
            rxs_nxt   = {rxs_r[7:4], hex_val(rx_byte)};
            phase_nxt = PH_TAIL;
          end
          default: ;
        endcase
      end

      if (rx_byte == CH_LF && cr_r) begin
        emit      = 1'b1;
        phase_nxt = PH_IDLE;
        cr_nxt    = 1'b0;
      end else begin
        cr_nxt = (rx_byte == CH_CR);
      end
    end
  end

  // Result is formed from the state as it stands after this byte.
  assign id_fin   = (fidx_nxt == '0 && cidx_nxt != 3'd5) ? '0 : id_nxt;
  assign kind_fin = kind_of(id_fin);
  assign ok       = (xor_nxt == rxs_nxt);

  always_comb begin
    res                   = '0;
    res.checksum_ok       = ok;
    res.computed_checksum = xor_nxt;
    res.received_checksum = rxs_nxt;
    res.sentence_kind     = kind_fin;
    if (ok && (kind_fin == KIND_GLL || kind_fin == KIND_RMC) && td_nxt[5] != NIB_EMPTY) begin
      res.time_present = 1'b1;
      res.utc_hour     = two_digits(td_nxt[5], td_nxt[4]);
      res.utc_minute   = two_digits(td_nxt[3], td_nxt[2]);
      res.utc_second   = two_digits(td_nxt[1], td_nxt[0]);
    end
    if (ok && kind_fin == KIND_GSV && gmsg_nxt[6:0] == 7'd1) begin
      res.sats_present = 1'b1;
      res.sats_in_view = (gcnt_nxt[6:0] > 7'd99) ? 7'd99 : gcnt_nxt[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      xor_r   <= '0;
      rxs_r   <= '0;
      fidx_r  <= '0;
      cidx_r  <= '0;
      id_r    <= '0;
      td_r    <= '0;
      gmsg_r  <= '0;
      gcnt_r  <= '0;
      cr_r    <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      xor_r   <= xor_nxt;
      rxs_r   <= rxs_nxt;
      fidx_r  <= fidx_nxt;
      cidx_r  <= cidx_nxt;
      id_r    <= id_nxt;
      td_r    <= td_nxt;
      gmsg_r  <= gmsg_nxt;
      gcnt_r  <= gcnt_nxt;
      cr_r    <= cr_nxt;
    end
  end

  a_emit_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    step && emit |=> phase_r == PH_IDLE)
    else $error("phase not idle after sentence end");

  a_emit_in_sentence: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> active && cr_r)
    else $error("result raised outside a sentence");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && !active && rx_byte == CH_DOLLAR |=> phase_r == PH_BODY && xor_r == '0 && fidx_r == '0)
    else $error("sentence start did not clear state");

  a_sats_gsv: assert property (@(posedge clk) disable iff (!rst_n)
    emit && res.sats_present |-> res.sentence_kind == KIND_GSV && res.checksum_ok)
    else $error("satellite count outside a good GSV sentence");

endmodule

/* rtl/nmea_sentence_checker.sv */
// Top level of the NMEA sentence checker: input word register, parser, result register.
// Depends on nmea_chk_pkg and nmea_chk_parser.
//
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | in_rx_byte (8)
//  out_    | output    | out_valid/out_stall| checksum, kind, UTC time, satellites
//
// One word per cycle unless in_stall is high: a received byte is registered, then
// updates the sentence state and, on CR then LF, loads the result register.
// A byte that ends a sentence waits in the input register while the previous
// result is stalled; other bytes pass regardless of out_stall.
// rst_n is synchronous: the block waits for '$' with both registers empty.
module nmea_sentence_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       in_rx_byte,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_checksum_ok,
  output logic [7:0]                       out_computed_checksum,
  output logic [7:0]                       out_received_checksum,
  output logic [nmea_chk_pkg::KIND_W-1:0]  out_sentence_kind,
  output logic                             out_time_present,
  output logic [nmea_chk_pkg::NUM_W-1:0]   out_utc_hour,
  output logic [nmea_chk_pkg::NUM_W-1:0]   out_utc_minute,
  output logic [nmea_chk_pkg::NUM_W-1:0]   out_utc_second,
  output logic                             out_sats_present,
  output logic [nmea_chk_pkg::NUM_W-1:0]   out_sats_in_view
);
  import nmea_chk_pkg::*;

  logic       byte_v_r, byte_v_nxt;
  logic [7:0] byte_r;
  logic       out_v_r, out_v_nxt;
  nmea_res_t  out_res_r;
  nmea_res_t  res;
  logic       emit;
  logic       out_free;
  logic       proc;
  logic       in_acc;

  nmea_chk_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (proc),
    .rx_byte (byte_r),
    .emit    (emit),
    .res     (res)
  );

  assign out_free = !out_v_r || !out_stall;
  assign proc     = byte_v_r && (!emit || out_free);
  assign in_stall = byte_v_r && !proc;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    byte_v_nxt = byte_v_r;
    if (in_acc) byte_v_nxt = 1'b1;
    else if (proc) byte_v_nxt = 1'b0;

    out_v_nxt = out_v_r;
    if (proc && emit) out_v_nxt = 1'b1;
    else if (!out_stall) out_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      byte_v_r <= byte_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) byte_r <= in_rx_byte;
    if (proc && emit) out_res_r <= res;
  end

  assign out_valid             = out_v_r;
  assign out_checksum_ok       = out_res_r.checksum_ok;
  assign out_computed_checksum = out_res_r.computed_checksum;
  assign out_received_checksum = out_res_r.received_checksum;
  assign out_sentence_kind     = out_res_r.sentence_kind;
  assign out_time_present      = out_res_r.time_present;
  assign out_utc_hour          = out_res_r.utc_hour;
  assign out_utc_minute        = out_res_r.utc_minute;
  assign out_utc_second        = out_res_r.utc_second;
  assign out_sats_present      = out_res_r.sats_present;
  assign out_sats_in_view      = out_res_r.sats_in_view;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    proc && emit |-> !out_v_r || !out_stall)
    else $error("pending result overwritten");

  a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_stall && !(proc && emit) |=> !out_v_r)
    else $error("taken result still shown");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> byte_v_r && $stable(byte_r))
    else $error("stalled input word lost");

endmodule
